// ----- src/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master package
// Shared types and constants for the register transaction I2C master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
    localparam int         FIFO_DEPTH_DEF  = 4;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_POINT = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [15:0] {
        PH_IDLE      = 16'h0001,
        PH_START1    = 16'h0002,
        PH_START2    = 16'h0004,
        PH_TX_LOW    = 16'h0008,
        PH_TX_HIGH   = 16'h0010,
        PH_ACK_LOW   = 16'h0020,
        PH_ACK_HIGH  = 16'h0040,
        PH_ACK_END   = 16'h0080,
        PH_RX_HIGH   = 16'h0100,
        PH_RX_LOW    = 16'h0200,
        PH_MACK_LOW  = 16'h0400,
        PH_MACK_HIGH = 16'h0800,
        PH_MACK_END  = 16'h1000,
        PH_STOP1     = 16'h2000,
        PH_STOP2     = 16'h4000,
        PH_STOP3     = 16'h8000
    } t_phase;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  device_address;
        logic [7:0]  register_index;
        logic [15:0] write_data;
        logic        take_magnitude;
        logic        sda_in;
    } t_in;

    typedef struct packed {
        logic        scl_out;
        logic        sda_out;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_word;
        logic        ack_error;
    } t_out;

    typedef struct packed {
        logic        start;
        t_cmd        cmd;
        logic [7:0]  addr_byte;
        logic [7:0]  reg_byte;
        logic [15:0] wdata;
        logic        mag;
        logic        sda_in;
    } t_work;

endpackage

// ----- src/i2c_master_register_transactions.sv -----
// ----------------------------------------------------------------------------
// I2C master for 16-bit register transactions
// Drives SCL and SDA one bus phase per tick word and runs register write,
// pointer set and register read transactions with acknowledge timeout.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+-----------
//   in      | input     | i_in_valid / o_in_ready | i_in_data
//   out     | output    | o_out_valid/ i_out_ready| o_out_data
//   cfg     | input     | i_cfg_we                | i_cfg_data
//
// One tick word is accepted per cycle while the work queue has room. Each
// word is registered in the work queue, then taken by the bus engine, whose
// result word is registered in the output stage.
// The rate is bounded by the single-phase step of the bus engine.
// Synchronous active-low reset returns the bus to idle and the timeout to 250.
// The work queue holds FIFO_DEPTH words and the output stage one more before
// an output stall stops the input.
// ----------------------------------------------------------------------------
module i2c_master_register_transactions import i2cm_pkg::*; #(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out_data
);

    logic  front_valid, front_ready;
    t_work front_work;
    logic  q_valid, q_ready;
    t_work q_work;

    i2cm_front u_front (
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_work  (front_work)
    );

    i2cm_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_work  (front_work),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_work  (q_work)
    );

    i2cm_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (q_valid),
        .o_ready    (q_ready),
        .i_work     (q_work),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out_data)
    );

endmodule

// ----- src/i2cm_front.sv -----
// ----------------------------------------------------------------------------
// I2C master front end
// Accepts words and decodes them into work entries for the bus engine.
// ----------------------------------------------------------------------------
module i2cm_front import i2cm_pkg::*; (
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_in   i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_work o_work
);

    t_cmd cmd;

    assign cmd     = t_cmd'(i_data.command);
    assign o_valid = i_valid & i_rst_n;
    assign o_ready = i_ready & i_rst_n;

    always_comb begin
        o_work          = '0;
        o_work.start    = (cmd != CMD_TICK);
        o_work.cmd      = cmd;
        o_work.reg_byte = i_data.register_index;
        o_work.wdata    = i_data.write_data;
        o_work.mag      = i_data.take_magnitude;
        o_work.sda_in   = i_data.sda_in;
        unique case (cmd)
            CMD_READ: begin
                o_work.addr_byte = i_data.device_address + 8'd1;
            end
            default: begin
                o_work.addr_byte = i_data.device_address;
            end
        endcase
    end

endmodule

// ----- src/i2cm_fifo.sv -----
// ----------------------------------------------------------------------------
// I2C master work queue
// Short queue that decouples the front end from the bus engine.
// ----------------------------------------------------------------------------
module i2cm_fifo import i2cm_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_work i_work,
    output logic  o_valid,
    input  logic  i_ready,
    output t_work o_work
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_work          r_mem [DEPTH];
    logic [AW-1:0]  r_wp, n_wp;
    logic [AW-1:0]  r_rp, n_rp;
    logic [CW-1:0]  r_cnt;
    logic           push, pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_work  = r_mem[r_rp];
    assign push    = i_valid & o_ready;
    assign pop     = o_valid & i_ready;

    assign n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
    assign n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= n_wp;
            end
            if (pop) begin
                r_rp <= n_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ----- src/i2cm_engine.sv -----
// ----------------------------------------------------------------------------
// I2C master bus engine
// Advances the bus state machine by one phase per work entry and registers
// the resulting line levels and status in the output stage.
// ----------------------------------------------------------------------------
module i2cm_engine import i2cm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_work      i_work,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out       o_data
);

    t_phase       r_phase, n_phase;
    logic [3:0]   r_bit, n_bit;
    logic [1:0]   r_byte, n_byte;
    logic [7:0]   r_shift, n_shift;
    logic [15:0]  r_data, n_data;
    logic [7:0]   r_poll, n_poll;
    t_cmd         r_cmd, n_cmd;
    logic [7:0]   r_addr, n_addr;
    logic [7:0]   r_reg, n_reg;
    logic         r_mag, n_mag;
    logic         r_err, n_err;
    logic [7:0]   r_timeout;
    t_out         r_out;
    logic         r_out_valid;
    t_out         res;
    logic         pop;
    logic [8:0]   poll_inc;
    logic [1:0]   tx_idx;
    logic         tx_next;

    function automatic logic [7:0] f_tx_byte(input logic [1:0] idx, input logic [7:0] addr,
                                             input logic [7:0] rg, input logic [15:0] dw);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            2'd0:    b = addr;
            2'd1:    b = rg;
            2'd2:    b = dw[15:8];
            default: b = dw[7:0];
        endcase
        return b;
    endfunction

    assign pop      = i_valid & (!r_out_valid | i_ready);
    assign o_ready  = !r_out_valid | i_ready;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;
    assign poll_inc = {1'b0, r_poll} + 9'd1;
    assign tx_idx   = r_byte + 2'd1;
    assign tx_next  = ((r_cmd == CMD_WRITE) && (r_byte < 2'd3)) ||
                      ((r_cmd == CMD_POINT) && (r_byte < 2'd1));

    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        n_byte  = r_byte;
        n_shift = r_shift;
        n_data  = r_data;
        n_poll  = r_poll;
        n_cmd   = r_cmd;
        n_addr  = r_addr;
        n_reg   = r_reg;
        n_mag   = r_mag;
        n_err   = r_err;
        res          = '0;
        res.scl_out  = 1'b1;
        res.sda_out  = 1'b1;
        res.busy_res = 1'b1;
        unique case (r_phase)
            PH_START1: begin
                res.sda_out = 1'b0;
                n_phase     = PH_START2;
            end
            PH_START2: begin
                res.scl_out = 1'b0;
                res.sda_out = 1'b0;
                n_byte      = 2'd0;
                n_shift     = f_tx_byte(2'd0, r_addr, r_reg, r_data);
                n_bit       = 4'd0;
                n_phase     = PH_TX_LOW;
            end
            PH_TX_LOW: begin
                res.scl_out = 1'b0;
                res.sda_out = r_shift[7];
                n_phase     = PH_TX_HIGH;
            end
            PH_TX_HIGH: begin
                res.sda_out = r_shift[7];
                n_shift     = {r_shift[6:0], 1'b0};
                n_bit       = r_bit + 4'd1;
                if (n_bit >= 4'd8) begin
                    n_poll  = 8'd0;
                    n_phase = PH_ACK_LOW;
                end else begin
                    n_phase = PH_TX_LOW;
                end
            end
            PH_ACK_LOW: begin
                res.scl_out = 1'b0;
                n_phase     = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
                if (!i_work.sda_in) begin
                    n_phase = PH_ACK_END;
                end else if (poll_inc > {1'b0, r_timeout}) begin
                    n_err   = 1'b1;
                    n_phase = PH_STOP1;
                end else begin
                    n_poll  = poll_inc[7:0];
                end
            end
            PH_ACK_END: begin
                res.scl_out = 1'b0;
                if (tx_next) begin
                    n_byte  = tx_idx;
                    n_shift = f_tx_byte(tx_idx, r_addr, r_reg, r_data);
                    n_bit   = 4'd0;
                    n_phase = PH_TX_LOW;
                end else if (r_cmd == CMD_READ) begin
                    n_byte  = 2'd1;
                    n_bit   = 4'd0;
                    n_shift = 8'd0;
                    n_data  = 16'd0;
                    n_phase = PH_RX_HIGH;
                end else begin
                    n_phase = PH_STOP1;
                end
            end
            PH_RX_HIGH: begin
                n_shift = {r_shift[6:0], i_work.sda_in};
                n_bit   = r_bit + 4'd1;
                n_phase = PH_RX_LOW;
            end
            PH_RX_LOW: begin
                res.scl_out = 1'b0;
                if (r_bit >= 4'd8) begin
                    n_data  = {r_data[7:0], r_shift};
                    n_phase = PH_MACK_LOW;
                end else begin
                    n_phase = PH_RX_HIGH;
                end
            end
            PH_MACK_LOW: begin
                res.scl_out = 1'b0;
                res.sda_out = (r_byte != 2'd1);
                n_phase     = PH_MACK_HIGH;
            end
            PH_MACK_HIGH: begin
                res.sda_out = (r_byte != 2'd1);
                n_phase     = PH_MACK_END;
            end
            PH_MACK_END: begin
                res.scl_out = 1'b0;
                if (r_byte == 2'd1) begin
                    n_byte  = 2'd2;
                    n_bit   = 4'd0;
                    n_shift = 8'd0;
                    n_phase = PH_RX_HIGH;
                end else begin
                    n_phase = PH_STOP1;
                end
            end
            PH_STOP1: begin
                res.scl_out = 1'b0;
                res.sda_out = 1'b0;
                n_phase     = PH_STOP2;
            end
            PH_STOP2: begin
                res.sda_out = 1'b0;
                n_phase     = PH_STOP3;
            end
            PH_STOP3: begin
                res.busy_res  = 1'b0;
                res.done_res  = 1'b1;
                res.ack_error = r_err;
                if ((r_cmd == CMD_READ) && !r_err) begin
                    if (r_mag && r_data[15]) begin
                        res.read_word = 16'd0 - r_data;
                    end else begin
                        res.read_word = r_data;
                    end
                end
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_work.start) begin
                    n_cmd   = i_work.cmd;
                    n_addr  = i_work.addr_byte;
                    n_reg   = i_work.reg_byte;
                    n_data  = i_work.wdata;
                    n_mag   = i_work.mag;
                    n_err   = 1'b0;
                    n_byte  = 2'd0;
                    n_bit   = 4'd0;
                    n_poll  = 8'd0;
                    n_shift = 8'd0;
                    n_phase = PH_START1;
                end else begin
                    res.busy_res = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit       <= '0;
            r_byte      <= '0;
            r_shift     <= '0;
            r_data      <= '0;
            r_poll      <= '0;
            r_cmd       <= CMD_TICK;
            r_addr      <= '0;
            r_reg       <= '0;
            r_mag       <= 1'b0;
            r_err       <= 1'b0;
            r_timeout   <= ACK_TIMEOUT_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (pop) begin
                r_phase <= n_phase;
                r_bit   <= n_bit;
                r_byte  <= n_byte;
                r_shift <= n_shift;
                r_data  <= n_data;
                r_poll  <= n_poll;
                r_cmd   <= n_cmd;
                r_addr  <= n_addr;
                r_reg   <= n_reg;
                r_mag   <= n_mag;
                r_err   <= n_err;
            end
            r_out_valid <= pop | (r_out_valid & !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= res;
        end
    end

    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("bus phase is not one-hot");

    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pop |=> $stable(r_phase))
        else $error("bus phase moved without a work entry");

    a_stop_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && (r_phase == PH_STOP3) |=> (r_phase == PH_IDLE) && r_out.done_res)
        else $error("stop did not finish the transaction");

    a_status_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.done_res |-> (r_out.read_word == 16'd0) && !r_out.ack_error)
        else $error("read word or error shown outside the finishing tick");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= 4'd8)
        else $error("bit counter out of range");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Testbench for the register transaction I2C master
// Plays the sensor side of the bus from predicted bus phases: it acknowledges
// bytes, holds acknowledges off or lets them time out, and shifts out read
// data. Every tick word has its expected bus levels worked out by a
// cycle-level model of the master. Each result word is compared against that
// model, field by field, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_WORDS  = 200;
    localparam int HOLD_OFF_LONG = 150;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in        i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out       o_out_data;

    // Bus master model.
    t_phase      bus_phase   = PH_IDLE;
    logic [3:0]  bit_cnt     = '0;
    logic [1:0]  byte_cnt    = '0;
    logic [7:0]  shift_reg   = '0;
    logic [15:0] data_reg    = '0;
    logic [7:0]  poll_cnt    = '0;
    t_cmd        cur_cmd     = CMD_TICK;
    logic [7:0]  cur_addr    = '0;
    logic [7:0]  cur_reg     = '0;
    logic        cur_mag     = 1'b0;
    logic        err_flag    = 1'b0;
    logic [7:0]  ack_limit   = ACK_TIMEOUT_RST;

    t_out pending_bus_levels[$];
    int   mismatches    = 0;
    int   words_sent    = 0;
    int   burst_left    = 0;
    bit   gaps_on       = 1'b1;
    int   hold_off      = 0;
    int   hold_requests = 0;
    int   hold_served   = 0;
    int   ready_mode    = 0;
    int   mode_left     = 0;
    int   quiet_cycles  = 0;

    i2c_master_register_transactions DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void load_tx_byte(logic [1:0] idx);
        byte_cnt = idx;
        case (idx)
            2'd0: shift_reg = (cur_cmd == CMD_READ) ? cur_addr + 8'd1 : cur_addr;
            2'd1: shift_reg = cur_reg;
            2'd2: shift_reg = data_reg[15:8];
            default: shift_reg = data_reg[7:0];
        endcase
        bit_cnt = '0;
        bus_phase = PH_TX_LOW;
    endfunction

    function automatic t_out next_bus_levels(t_in w);
        t_out        r;
        logic [8:0]  polls;
        logic [15:0] v;
        r = '0;
        r.scl_out = 1'b1;
        r.sda_out = 1'b1;
        r.busy_res = 1'b1;
        case (bus_phase)
            PH_START1: begin
                r.sda_out = 1'b0;
                bus_phase = PH_START2;
            end
            PH_START2: begin
                r.scl_out = 1'b0;
                r.sda_out = 1'b0;
                load_tx_byte(2'd0);
            end
            PH_TX_LOW: begin
                r.scl_out = 1'b0;
                r.sda_out = shift_reg[7];
                bus_phase = PH_TX_HIGH;
            end
            PH_TX_HIGH: begin
                r.sda_out = shift_reg[7];
                shift_reg = shift_reg << 1;
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= 4'd8) begin
                    poll_cnt = '0;
                    bus_phase = PH_ACK_LOW;
                end else begin
                    bus_phase = PH_TX_LOW;
                end
            end
            PH_ACK_LOW: begin
                r.scl_out = 1'b0;
                bus_phase = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
                if (!w.sda_in) begin
                    bus_phase = PH_ACK_END;
                end else begin
                    polls = {1'b0, poll_cnt} + 9'd1;
                    if (polls > {1'b0, ack_limit}) begin
                        err_flag = 1'b1;
                        bus_phase = PH_STOP1;
                    end else begin
                        poll_cnt = polls[7:0];
                    end
                end
            end
            PH_ACK_END: begin
                r.scl_out = 1'b0;
                if (cur_cmd == CMD_WRITE && byte_cnt < 2'd3) begin
                    load_tx_byte(byte_cnt + 2'd1);
                end else if (cur_cmd == CMD_POINT && byte_cnt < 2'd1) begin
                    load_tx_byte(byte_cnt + 2'd1);
                end else if (cur_cmd == CMD_READ) begin
                    byte_cnt = 2'd1;
                    bit_cnt = '0;
                    shift_reg = '0;
                    data_reg = '0;
                    bus_phase = PH_RX_HIGH;
                end else begin
                    bus_phase = PH_STOP1;
                end
            end
            PH_RX_HIGH: begin
                shift_reg = {shift_reg[6:0], w.sda_in};
                bit_cnt = bit_cnt + 4'd1;
                bus_phase = PH_RX_LOW;
            end
            PH_RX_LOW: begin
                r.scl_out = 1'b0;
                if (bit_cnt >= 4'd8) begin
                    data_reg = {data_reg[7:0], shift_reg};
                    bus_phase = PH_MACK_LOW;
                end else begin
                    bus_phase = PH_RX_HIGH;
                end
            end
            PH_MACK_LOW: begin
                r.scl_out = 1'b0;
                r.sda_out = (byte_cnt != 2'd1);
                bus_phase = PH_MACK_HIGH;
            end
            PH_MACK_HIGH: begin
                r.sda_out = (byte_cnt != 2'd1);
                bus_phase = PH_MACK_END;
            end
            PH_MACK_END: begin
                r.scl_out = 1'b0;
                if (byte_cnt == 2'd1) begin
                    byte_cnt = 2'd2;
                    bit_cnt = '0;
                    shift_reg = '0;
                    bus_phase = PH_RX_HIGH;
                end else begin
                    bus_phase = PH_STOP1;
                end
            end
            PH_STOP1: begin
                r.scl_out = 1'b0;
                r.sda_out = 1'b0;
                bus_phase = PH_STOP2;
            end
            PH_STOP2: begin
                r.sda_out = 1'b0;
                bus_phase = PH_STOP3;
            end
            PH_STOP3: begin
                r.busy_res = 1'b0;
                r.done_res = 1'b1;
                r.ack_error = err_flag;
                if (cur_cmd == CMD_READ && !err_flag) begin
                    v = data_reg;
                    if (cur_mag && v[15]) begin
                        v = ~(v - 16'd1);
                    end
                    r.read_word = v;
                end
                bus_phase = PH_IDLE;
            end
            default: begin
                bus_phase = PH_IDLE;
                if (t_cmd'(w.command) != CMD_TICK) begin
                    cur_cmd = t_cmd'(w.command);
                    cur_addr = w.device_address;
                    cur_reg = w.register_index;
                    data_reg = w.write_data;
                    cur_mag = w.take_magnitude;
                    err_flag = 1'b0;
                    byte_cnt = '0;
                    bit_cnt = '0;
                    poll_cnt = '0;
                    shift_reg = '0;
                    bus_phase = PH_START1;
                end else begin
                    r.busy_res = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    function automatic t_in random_tick();
        t_in w;
        w.command = 2'($urandom_range(0, 3));
        w.device_address = 8'($urandom_range(0, 255));
        w.register_index = 8'($urandom_range(0, 255));
        w.write_data = 16'($urandom_range(0, 65535));
        w.take_magnitude = 1'($urandom_range(0, 1));
        w.sda_in = 1'($urandom_range(0, 1));
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
    endtask

    task automatic send_word(t_in w);
        if (burst_left == 0) begin
            if (gaps_on) begin
                repeat ($urandom_range(0, 6)) begin
                    @(negedge i_clk);
                    i_in_valid <= 1'b0;
                end
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_bus_levels.push_back(next_bus_levels(w));
        words_sent++;
    endtask

    task automatic wait_bus_quiet();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_bus_levels.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_ack_timeout(logic [7:0] v);
        wait_bus_quiet();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        ack_limit = v;
    endtask

    // Starts one transaction and answers for the sensor until the bus is idle
    // again. Each acknowledge is held off for slow_polls polls, or is random
    // when noisy is set.
    task automatic run_transfer(t_cmd c, logic [7:0] a, logic [7:0] r, logic [15:0] d,
                                logic m, int slow_polls, logic [15:0] rx_data, bit noisy);
        t_in w;
        int  polls_seen;
        int  idx;
        polls_seen = 0;
        w = random_tick();
        w.command = c;
        w.device_address = a;
        w.register_index = r;
        w.write_data = d;
        w.take_magnitude = m;
        send_word(w);
        while (bus_phase != PH_IDLE) begin
            w = random_tick();
            case (bus_phase)
                PH_ACK_LOW: polls_seen = 0;
                PH_ACK_HIGH: begin
                    w.sda_in = noisy ? 1'($urandom_range(0, 1)) : (polls_seen < slow_polls);
                    polls_seen++;
                end
                PH_RX_HIGH: begin
                    idx = (byte_cnt == 2'd1) ? 15 - int'(bit_cnt) : 7 - int'(bit_cnt);
                    w.sda_in = rx_data[idx];
                end
                default: ;
            endcase
            send_word(w);
        end
    endtask

    task automatic test_idle_ticks();
        run_transfer(CMD_TICK, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 0, 16'h0000, 1'b0);
        run_transfer(CMD_TICK, 8'h00, 8'h00, 16'h0000, 1'b0, 0, 16'h0000, 1'b0);
        run_transfer(CMD_TICK, 8'hA5, 8'h5A, 16'hC33C, 1'b1, 0, 16'h0000, 1'b0);
    endtask

    task automatic test_register_write();
        run_transfer(CMD_WRITE, 8'hFF, 8'h00, 16'hFFFF, 1'b0, 0, 16'h0000, 1'b0);
        run_transfer(CMD_WRITE, 8'h00, 8'hFF, 16'h0000, 1'b1, 0, 16'h0000, 1'b0);
        run_transfer(CMD_WRITE, 8'h80, 8'h01, 16'h8001, 1'b0, 2, 16'h0000, 1'b0);
    endtask

    task automatic test_pointer_set();
        run_transfer(CMD_POINT, 8'h80, 8'h7F, 16'hFFFF, 1'b1, 0, 16'h0000, 1'b0);
        run_transfer(CMD_POINT, 8'h7F, 8'h80, 16'h0000, 1'b0, 1, 16'h0000, 1'b0);
    endtask

    task automatic test_register_read();
        // The read address wraps from 0xFF to 0x00.
        run_transfer(CMD_READ, 8'hFF, 8'h02, 16'h0000, 1'b1, 0, 16'h8000, 1'b0);
        run_transfer(CMD_READ, 8'h80, 8'hFE, 16'hFFFF, 1'b1, 0, 16'hFFFF, 1'b0);
        run_transfer(CMD_READ, 8'h00, 8'h00, 16'h0000, 1'b1, 0, 16'h7FFF, 1'b0);
        run_transfer(CMD_READ, 8'h40, 8'h11, 16'h0000, 1'b0, 0, 16'h8001, 1'b0);
        run_transfer(CMD_READ, 8'h41, 8'h22, 16'h0000, 1'b1, 3, 16'h0000, 1'b0);
    endtask

    task automatic test_ack_timeout();
        set_ack_timeout(8'd0);
        run_transfer(CMD_WRITE, 8'h90, 8'h05, 16'h1234, 1'b0, 1, 16'h0000, 1'b0);
        run_transfer(CMD_READ, 8'h90, 8'h05, 16'h0000, 1'b1, 1, 16'hFFFF, 1'b0);
        run_transfer(CMD_READ, 8'h90, 8'h05, 16'h0000, 1'b1, 0, 16'hFFFE, 1'b0);
        set_ack_timeout(8'd255);
        run_transfer(CMD_POINT, 8'h92, 8'h06, 16'h0000, 1'b0, 256, 16'h0000, 1'b0);
        set_ack_timeout(8'd3);
        run_transfer(CMD_WRITE, 8'h94, 8'h07, 16'hA55A, 1'b0, 3, 16'h0000, 1'b0);
        run_transfer(CMD_READ, 8'h94, 8'h07, 16'h0000, 1'b0, 4, 16'h1234, 1'b0);
        set_ack_timeout(ACK_TIMEOUT_RST);
    endtask

    task automatic test_output_stall();
        gaps_on = 1'b0;
        @(negedge i_clk);
        hold_requests++;
        run_transfer(CMD_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     16'($urandom_range(0, 65535)), 1'b0, 0, 16'h0000, 1'b0);
        run_transfer(CMD_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     16'h0000, 1'b1, 0, 16'($urandom_range(0, 65535)), 1'b0);
        wait_bus_quiet();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int       target;
        int       pick;
        int       slow;
        int       transfers;
        logic [7:0] limit_pick;
        target = words_sent + RANDOM_WORDS;
        transfers = 0;
        while (words_sent < target) begin
            if (transfers % 3 == 2) begin
                case ($urandom_range(0, 7))
                    0: limit_pick = 8'd0;
                    1: limit_pick = 8'd1;
                    2: limit_pick = 8'd2;
                    3: limit_pick = 8'd255;
                    4: limit_pick = ACK_TIMEOUT_RST;
                    5: limit_pick = 8'($urandom_range(0, 255));
                    default: limit_pick = 8'($urandom_range(3, 12));
                endcase
                set_ack_timeout(limit_pick);
            end
            transfers++;
            pick = $urandom_range(0, 11);
            slow = (pick == 0) ? int'(ack_limit) + 1 :
                   (pick < 4 ? int'($urandom_range(1, 3)) : 0);
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(1, 5)) begin
                    run_transfer(CMD_TICK, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)),
                                 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), 0,
                                 16'h0000, 1'b0);
                end
            end else begin
                run_transfer(pick < 4 ? CMD_WRITE : (pick < 6 ? CMD_POINT : CMD_READ),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), slow,
                             16'($urandom_range(0, 65535)), $urandom_range(0, 7) == 0);
            end
        end
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_off = HOLD_OFF_LONG;
                hold_served = hold_requests;
            end
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_off > 0) begin
                i_out_ready <= 1'b0;
                hold_off--;
            end else begin
                case (ready_mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 3) != 0);
                    2: i_out_ready <= ($urandom_range(0, 9) < 3);
                    default: i_out_ready <= (mode_left % 4 != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_bus_levels.size() == 0) begin
                report_mismatch("unexpected word", 32'(o_out_data), 32'h0);
            end else begin
                want = pending_bus_levels.pop_front();
                if (o_out_data.scl_out !== want.scl_out)
                    report_mismatch("scl_out", 32'(o_out_data.scl_out), 32'(want.scl_out));
                if (o_out_data.sda_out !== want.sda_out)
                    report_mismatch("sda_out", 32'(o_out_data.sda_out), 32'(want.sda_out));
                if (o_out_data.busy_res !== want.busy_res)
                    report_mismatch("busy_res", 32'(o_out_data.busy_res),
                                    32'(want.busy_res));
                if (o_out_data.done_res !== want.done_res)
                    report_mismatch("done_res", 32'(o_out_data.done_res),
                                    32'(want.done_res));
                if (o_out_data.read_word !== want.read_word)
                    report_mismatch("read_word", 32'(o_out_data.read_word),
                                    32'(want.read_word));
                if (o_out_data.ack_error !== want.ack_error)
                    report_mismatch("ack_error", 32'(o_out_data.ack_error),
                                    32'(want.ack_error));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_ticks();
        test_register_write();
        test_pointer_set();
        test_register_read();
        test_ack_timeout();
        test_output_stall();
        test_random_traffic();

        wait_bus_quiet();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/i2cm_pkg.sv
src/i2cm_front.sv
src/i2cm_fifo.sv
src/i2cm_engine.sv
src/i2c_master_register_transactions.sv
tb/tb_top.sv
